// ===== rtl/rbnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbnh_pkg: shared types and constants
// Controller states, command and status groups, and the fixed-point constants
// of the ray versus box nearest-hit core.
// ----------------------------------------------------------------------------
package rbnh_pkg;

	localparam int MAX_OBJECTS_DEF = 64;
	localparam int Q_W             = 32;
	localparam int DIV_STEPS       = 48;
	localparam int NUM_AXES        = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int POS_OUT_W       = 6;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_DIR_X    = 3'd3;
	localparam logic [2:0] CFG_DIR_Y    = 3'd4;
	localparam logic [2:0] CFG_DIR_Z    = 3'd5;

	localparam logic signed [Q_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN    = 32'sh8000_0000;
	localparam logic signed [Q_W-1:0] Q_ONE    = 32'sh0001_0000;
	localparam logic signed [Q_W-1:0] MISS_DIST = 32'shFFFF_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AXIS,
		S_WAIT_A,
		S_WAIT_B,
		S_BEST,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic zchk;
		logic div_start;
		logic div_sel;
		logic t1_cap;
		logic axis_upd;
		logic best_upd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic test;
		logic d_zero;
		logic axis_last;
		logic div_done;
		logic last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/rbnh_div.sv =====
// ----------------------------------------------------------------------------
// rbnh_div: slab quotient divider
// Radix-2 restoring divide of (diff * 1.0) by a signed direction, one quotient
// bit a cycle, truncated toward zero and saturated to the Q16.16 range.
// ----------------------------------------------------------------------------
module rbnh_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [32:0]       num,
	input  logic signed [31:0]       den,
	output logic                     done,
	output logic signed [31:0]       quot
);

	localparam int CNT_W = $clog2(rbnh_pkg::DIV_STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [47:0]       num_q;
	logic [31:0]       den_q;
	logic [31:0]       rem_q;
	logic [47:0]       quo_q;
	logic              neg_q;

	logic [32:0]       num_mag;
	logic [32:0]       den_mag;
	logic [32:0]       rem_sh;
	logic [32:0]       rem_sub;
	logic              ge;

	always_comb begin
		num_mag = num[32] ? (33'd0 - num) : num;
		den_mag = den[31] ? (33'd0 - {den[31], den}) : {den[31], den};
		rem_sh  = {rem_q, num_q[47]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(rbnh_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {num_mag[31:0], 16'd0};
			den_q <= den_mag[31:0];
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[32] ^ den[31];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[46:0], ge};
			num_q <= {num_q[46:0], 1'b0};
		end
	end

	// saturate the magnitude, then apply the sign
	always_comb begin
		if (neg_q) begin
			if (quo_q > 48'h0000_8000_0000)
				quot = rbnh_pkg::Q_MIN;
			else
				quot = 32'sd0 - $signed(quo_q[31:0]);
		end else begin
			if (quo_q > 48'h0000_7FFF_FFFF)
				quot = rbnh_pkg::Q_MAX;
			else
				quot = $signed(quo_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== rtl/rbnh_datapath.sv =====
// ----------------------------------------------------------------------------
// rbnh_datapath: ray registers, box slab arithmetic and nearest-hit tracking
// Holds the ray, the current box, the running entry and exit distances, the
// best hit of the list and the result register.
// ----------------------------------------------------------------------------
module rbnh_datapath #(
	parameter int MAX_OBJECTS = rbnh_pkg::MAX_OBJECTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rbnh_pkg::cmd_t           cmd,
	output rbnh_pkg::status_t        status,
	input  logic                     cfg_valid,
	input  logic [2:0]               cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic signed [31:0]       box_min_x,
	input  logic signed [31:0]       box_min_y,
	input  logic signed [31:0]       box_min_z,
	input  logic signed [31:0]       box_max_x,
	input  logic signed [31:0]       box_max_y,
	input  logic signed [31:0]       box_max_z,
	input  logic                     object_valid,
	input  logic                     end_of_list,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic                     hit_found,
	output logic [5:0]               hit_index,
	output logic signed [31:0]       hit_distance,
	output logic                     list_overflow
);

	localparam int CNT_W = $clog2(MAX_OBJECTS + 2);

	logic signed [31:0] origin_q [3];
	logic signed [31:0] dir_q    [3];
	logic signed [31:0] bmin_q   [3];
	logic signed [31:0] bmax_q   [3];
	logic               last_q;
	logic               test_q;
	logic [1:0]         axis_q;
	logic               miss_q;
	logic signed [31:0] enter_q;
	logic signed [31:0] leave_q;
	logic signed [31:0] t1_q;

	logic [CNT_W-1:0]   count_q;
	logic               cut_q;
	logic               found_q;
	logic [5:0]         best_pos_q;
	logic signed [31:0] best_q;

	logic               out_valid_q;
	logic               out_found_q;
	logic [5:0]         out_index_q;
	logic signed [31:0] out_dist_q;
	logic               out_ovf_q;

	logic signed [31:0] o_ax, d_ax, a_ax, b_ax, lo_ax, hi_ax;
	logic signed [32:0] diff;
	logic signed [31:0] quot;
	logic signed [31:0] tn, tf;
	logic               div_done;
	logic [CNT_W+5:0]   pos_ext;
	logic               take;

	always_comb begin
		o_ax  = origin_q[axis_q];
		d_ax  = dir_q[axis_q];
		a_ax  = bmin_q[axis_q];
		b_ax  = bmax_q[axis_q];
		lo_ax = (a_ax < b_ax) ? a_ax : b_ax;
		hi_ax = (a_ax < b_ax) ? b_ax : a_ax;
		diff  = cmd.div_sel ? ({b_ax[31], b_ax} - {o_ax[31], o_ax})
		                    : ({a_ax[31], a_ax} - {o_ax[31], o_ax});
		tn    = (t1_q < quot) ? t1_q : quot;
		tf    = (t1_q < quot) ? quot : t1_q;
		pos_ext = {6'd0, count_q};
		take  = test_q && !miss_q && (leave_q > enter_q) && (!found_q || enter_q < best_q);
	end

	rbnh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (diff),
		.den    (d_ax),
		.done   (div_done),
		.quot   (quot)
	);

	// ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				dir_q[i]    <= '0;
			end
			dir_q[2] <= rbnh_pkg::Q_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbnh_pkg::CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				rbnh_pkg::CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				rbnh_pkg::CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				rbnh_pkg::CFG_DIR_X:    dir_q[0]    <= cfg_data;
				rbnh_pkg::CFG_DIR_Y:    dir_q[1]    <= cfg_data;
				rbnh_pkg::CFG_DIR_Z:    dir_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// box payload and per-box slab state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bmin_q[0] <= box_min_x;
			bmin_q[1] <= box_min_y;
			bmin_q[2] <= box_min_z;
			bmax_q[0] <= box_max_x;
			bmax_q[1] <= box_max_y;
			bmax_q[2] <= box_max_z;
			last_q    <= end_of_list;
			test_q    <= !cut_q && object_valid && (count_q < CNT_W'(MAX_OBJECTS));
			axis_q    <= '0;
			miss_q    <= 1'b0;
			enter_q   <= rbnh_pkg::Q_MIN;
			leave_q   <= rbnh_pkg::Q_MAX;
		end else begin
			if (cmd.zchk) begin
				miss_q <= miss_q | !((lo_ax <= o_ax) && (o_ax <= hi_ax));
				axis_q <= axis_q + 1'b1;
			end
			if (cmd.t1_cap)
				t1_q <= quot;
			if (cmd.axis_upd) begin
				if (tn > enter_q)
					enter_q <= tn;
				if (tf < leave_q)
					leave_q <= tf;
				axis_q <= axis_q + 1'b1;
			end
		end
	end

	// list state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cut_q       <= 1'b0;
			found_q     <= 1'b0;
			best_pos_q  <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.load) begin
				if (count_q <= CNT_W'(MAX_OBJECTS))
					count_q <= count_q + 1'b1;
				if (!object_valid)
					cut_q <= 1'b1;
				best_pos_q <= best_pos_q;
			end
			if (cmd.best_upd && take) begin
				found_q    <= 1'b1;
				best_pos_q <= pos_ext[5:0] - 6'd1;
				best_q     <= enter_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				cut_q       <= 1'b0;
				found_q     <= 1'b0;
				best_pos_q  <= '0;
				best_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_found_q <= found_q;
			out_index_q <= found_q ? best_pos_q : 6'd0;
			out_dist_q  <= found_q ? best_q : rbnh_pkg::MISS_DIST;
			out_ovf_q   <= count_q > CNT_W'(MAX_OBJECTS);
		end
	end

	always_comb begin
		status.test      = test_q;
		status.d_zero    = (d_ax == 32'sd0);
		status.axis_last = (axis_q == 2'(rbnh_pkg::NUM_AXES - 1));
		status.div_done  = div_done;
		status.last      = last_q;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign hit_found     = out_found_q;
	assign hit_index     = out_index_q;
	assign hit_distance  = out_dist_q;
	assign list_overflow = out_ovf_q;

endmodule

// ===== rtl/rbnh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbnh_ctrl: sequencer for one box
// Walks the three axes, issuing two slab divides per axis with a nonzero
// direction, then updates the best hit and hands the result on at list end.
// ----------------------------------------------------------------------------
module rbnh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rbnh_pkg::status_t    status,
	output rbnh_pkg::cmd_t       cmd
);

	rbnh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rbnh_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rbnh_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = rbnh_pkg::S_AXIS;
				end
			end
			rbnh_pkg::S_AXIS: begin
				if (!status.test) begin
					state_d = rbnh_pkg::S_EMIT;
				end else if (status.d_zero) begin
					cmd.zchk = 1'b1;
					state_d  = status.axis_last ? rbnh_pkg::S_BEST : rbnh_pkg::S_AXIS;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = rbnh_pkg::S_WAIT_A;
				end
			end
			rbnh_pkg::S_WAIT_A: begin
				if (status.div_done) begin
					cmd.t1_cap    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_d       = rbnh_pkg::S_WAIT_B;
				end
			end
			rbnh_pkg::S_WAIT_B: begin
				if (status.div_done) begin
					cmd.axis_upd = 1'b1;
					state_d      = status.axis_last ? rbnh_pkg::S_BEST : rbnh_pkg::S_AXIS;
				end
			end
			rbnh_pkg::S_BEST: begin
				cmd.best_upd = 1'b1;
				state_d      = rbnh_pkg::S_EMIT;
			end
			rbnh_pkg::S_EMIT: begin
				if (!status.last) begin
					state_d = rbnh_pkg::S_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = rbnh_pkg::S_IDLE;
				end
			end
			default: state_d = rbnh_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/ray_box_nearest_hit_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_core: nearest ray hit over a list of boxes
// One box a beat on the input; one result beat at the end of each list.
// ----------------------------------------------------------------------------
// The ray is written through the configuration channel (origin then direction,
// indexes 0 to 5, signed Q16.16); the user must write it only while the core is
// idle, which the core itself does not enforce. Each input beat is one box; the
// core keeps the nearest hit of the list and returns one result beat on the box
// marked end_of_list. Each zero-direction axis of a box gets a slab check and
// each other axis two divides, then the best hit is updated; untested boxes
// skip this. One box is in work at a time. The single shared 48-step radix-2
// divider computes the two slab distances of each axis in turn. A finished
// result waits in an output register while the next list starts.
module ray_box_nearest_hit_core #(
	parameter int MAX_OBJECTS = rbnh_pkg::MAX_OBJECTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   box_min_x,
	input  logic signed [31:0]   box_min_y,
	input  logic signed [31:0]   box_min_z,
	input  logic signed [31:0]   box_max_x,
	input  logic signed [31:0]   box_max_y,
	input  logic signed [31:0]   box_max_z,
	input  logic                 object_valid,
	input  logic                 end_of_list,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit_found,
	output logic [5:0]           hit_index,
	output logic signed [31:0]   hit_distance,
	output logic                 list_overflow
);

	rbnh_pkg::cmd_t    cmd;
	rbnh_pkg::status_t status;

	assign cfg_ready = 1'b1;

	rbnh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rbnh_datapath #(
		.MAX_OBJECTS (MAX_OBJECTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.box_min_x     (box_min_x),
		.box_min_y     (box_min_y),
		.box_min_z     (box_min_z),
		.box_max_x     (box_max_x),
		.box_max_y     (box_max_y),
		.box_max_z     (box_max_z),
		.object_valid  (object_valid),
		.end_of_list   (end_of_list),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.hit_found     (hit_found),
		.hit_index     (hit_index),
		.hit_distance  (hit_distance),
		.list_overflow (list_overflow)
	);

	// one box at a time: an accepted beat closes the input for the next cycle
	a_one_box: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a box is in work");

	// the divider only finishes while a box is in work
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !in_ready)
		else $error("divider finished while idle");

	// a miss carries the miss distance and index zero
	a_miss_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_found |-> hit_distance == rbnh_pkg::MISS_DIST && hit_index == 6'd0)
		else $error("miss result malformed");

	// a result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result register overwritten");

endmodule
